// File: rtl/rrts_pkg.sv
package rrts_pkg;

   // Fixed field widths of the request and response payloads
   localparam int unsigned OP_W     = 2;
   localparam int unsigned ID_W     = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned TICK_W   = 32;

   // Number of distinct task ids the id field can name
   localparam int unsigned TASK_IDS = 1 << ID_W;

   // Slice length after reset
   localparam logic [CSR_W-1:0] SLICE_RESET = 16'd10;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE   = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
   localparam logic [OP_W-1:0] OP_YIELD     = 2'd2;
   localparam logic [OP_W-1:0] OP_TERMINATE = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

   // Ring control for one transfer
   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ID_W-1:0] push_id;
   } ring_ctl_type;

endpackage

// File: rtl/rrts_ring.sv
module rrts_ring #(
   parameter int unsigned MAX_TASKS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrts_pkg::ring_ctl_type           ctl,
   output logic [rrts_pkg::ID_W-1:0]        head_id,
   output logic [$clog2(MAX_TASKS+1)-1:0]   level_next
);

   localparam int unsigned PTR_W = $clog2(MAX_TASKS);
   localparam int unsigned LVL_W = $clog2(MAX_TASKS + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_TASKS - 1);

   logic [rrts_pkg::ID_W-1:0] mem [MAX_TASKS];

   logic [PTR_W-1:0]          head_ff, head_in;
   logic [PTR_W-1:0]          tail_ff, tail_in;
   logic [LVL_W-1:0]          level_ff, level_in;
   logic [rrts_pkg::ID_W-1:0] head_data_ff;

   // Advance the pointers and the fill level
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctl.pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
      end
      if (ctl.push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
      end
      case ({ctl.push, ctl.pop})
         2'b10:   level_in = level_ff + LVL_W'(1);
         2'b01:   level_in = level_ff - LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   // Write at the tail
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= ctl.push_id;
      end
   end

   // Prefetch the next head entry, taking a same-cycle write first
   always_ff @(posedge clock) begin
      if (ctl.push && (tail_ff == head_in)) begin
         head_data_ff <= ctl.push_id;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   // An empty ring can only pop the id pushed in the same transfer
   assign head_id    = (level_ff == '0) ? ctl.push_id : head_data_ff;
   assign level_next = level_in;

endmodule

// File: rtl/round_robin_task_scheduler_unit.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_opcode, req_task_id
// rsp      out        rsp_valid / rsp_ready  rsp_status .. rsp_tick_total
// csr      in         csr_valid / csr_ready  csr_data (slice length)
//
// Each request is decoded and applied to the scheduler state in the cycle it
// is accepted; its response sits in the output register from the next cycle.
// One request per cycle is accepted while rsp_ready is high; the ring head is
// prefetched from the ring memory so a pop never waits on a memory read.
// A stalled response holds the output register and blocks only further
// requests. Reset is synchronous: idle, empty ring, slice length 10.
module round_robin_task_scheduler_unit #(
   parameter int unsigned MAX_TASKS   = 16,
   parameter int unsigned SLICE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rrts_pkg::OP_W-1:0]           req_opcode,
   input  logic [rrts_pkg::ID_W-1:0]           req_task_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rrts_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_run_valid,
   output logic [rrts_pkg::ID_W-1:0]           rsp_run_task,
   output logic                                rsp_switched,
   output logic [rrts_pkg::ID_W-1:0]           rsp_prior_task,
   output logic [$clog2(MAX_TASKS+1)-1:0]      rsp_waiting_count,
   output logic [rrts_pkg::TICK_W-1:0]         rsp_tick_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rrts_pkg::CSR_W-1:0]          csr_data
);

   localparam int unsigned LVL_W = $clog2(MAX_TASKS + 1);
   localparam int unsigned IDS   = rrts_pkg::TASK_IDS;
   localparam int unsigned ID_W  = rrts_pkg::ID_W;

   logic                        req_fire;
   logic [rrts_pkg::CSR_W-1:0]  slice_len_ff;
   logic [SLICE_WIDTH-1:0]      slice_fresh;

   logic                        run_valid_ff, run_valid_in;
   logic [ID_W-1:0]             run_task_ff, run_task_in;
   logic [SLICE_WIDTH-1:0]      slice_left_ff, slice_left_in;
   logic [SLICE_WIDTH-1:0]      slice_dec;
   logic [rrts_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [IDS-1:0]              term_ff, term_in;
   logic [IDS-1:0]              queued_ff, queued_in;

   rrts_pkg::ring_ctl_type      ring_ctl;
   logic [ID_W-1:0]             head_id;
   logic [LVL_W-1:0]            level_next;
   logic [LVL_W-1:0]            level_now;
   logic                        ring_empty;

   logic [rrts_pkg::STATUS_W-1:0] status_in;
   logic                          switched_in;
   logic [ID_W-1:0]               prior_in;
   logic                          bad_id;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          rsp_run_valid_ff;
   logic [ID_W-1:0]               rsp_run_task_ff;
   logic                          rsp_switched_ff;
   logic [ID_W-1:0]               rsp_prior_ff;
   logic [LVL_W-1:0]              rsp_level_ff;
   logic [rrts_pkg::TICK_W-1:0]   rsp_tick_ff;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign slice_fresh = SLICE_WIDTH'(slice_len_ff);
   assign slice_dec   = slice_left_ff - SLICE_WIDTH'(1);
   assign bad_id      = (32'(req_task_id) >= MAX_TASKS);

   // Track the current fill level: after a transfer, level_next is the new one
   logic [LVL_W-1:0] level_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (req_fire) begin
         level_ff <= level_next;
      end
   end
   assign level_now  = level_ff;
   assign ring_empty = (level_now == '0);

   // Slice length register
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_len_ff <= rrts_pkg::SLICE_RESET;
      end else if (csr_valid && csr_ready) begin
         slice_len_ff <= csr_data;
      end
   end

   // Decode one request and work out the next scheduler state
   always_comb begin
      run_valid_in     = run_valid_ff;
      run_task_in      = run_task_ff;
      slice_left_in    = slice_left_ff;
      tick_in          = tick_ff;
      term_in          = term_ff;
      queued_in        = queued_ff;
      status_in        = rrts_pkg::STAT_DONE;
      ring_ctl.push    = 1'b0;
      ring_ctl.pop     = 1'b0;
      ring_ctl.push_id = run_task_ff;

      case (req_opcode)
         rrts_pkg::OP_ENQUEUE: begin
            ring_ctl.push_id = req_task_id;
            if (bad_id || term_ff[req_task_id] || queued_ff[req_task_id]
                || (run_valid_ff && (run_task_ff == req_task_id))) begin
               status_in = rrts_pkg::STAT_REJECT;
            end else if (level_now == LVL_W'(MAX_TASKS)) begin
               status_in = rrts_pkg::STAT_FULL;
            end else begin
               ring_ctl.push = 1'b1;
            end
         end
         rrts_pkg::OP_TICK: begin
            tick_in = tick_ff + rrts_pkg::TICK_W'(1);
            if (!run_valid_ff) begin
               ring_ctl.pop = !ring_empty;
            end else if (slice_dec == '0) begin
               ring_ctl.push = 1'b1;
               ring_ctl.pop  = 1'b1;
            end else begin
               slice_left_in = slice_dec;
            end
         end
         rrts_pkg::OP_YIELD: begin
            if (run_valid_ff && !ring_empty) begin
               ring_ctl.push = 1'b1;
               ring_ctl.pop  = 1'b1;
            end
         end
         rrts_pkg::OP_TERMINATE: begin
            if (run_valid_ff) begin
               term_in[run_task_ff] = 1'b1;
               ring_ctl.pop = !ring_empty;
               run_valid_in = !ring_empty;
            end
         end
         default: begin
            status_in = rrts_pkg::STAT_DONE;
         end
      endcase

      // Mark the pushed id, then clear the dispatched one
      if (ring_ctl.push) begin
         queued_in[ring_ctl.push_id] = 1'b1;
      end
      if (ring_ctl.pop) begin
         queued_in[head_id] = 1'b0;
         run_valid_in       = 1'b1;
         run_task_in        = head_id;
         slice_left_in      = slice_fresh;
      end

      // Hold everything when no transfer takes place
      if (!req_fire) begin
         ring_ctl.push = 1'b0;
         ring_ctl.pop  = 1'b0;
      end

      switched_in = (run_valid_ff != run_valid_in)
                    || (run_valid_ff && run_valid_in && (run_task_ff != run_task_in));
      prior_in    = (switched_in && run_valid_ff) ? run_task_ff : '0;
   end

   rrts_ring #(
      .MAX_TASKS (MAX_TASKS)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ring_ctl),
      .head_id    (head_id),
      .level_next (level_next)
   );

   // Scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff  <= 1'b0;
         run_task_ff   <= '0;
         slice_left_ff <= '0;
         tick_ff       <= '0;
         term_ff       <= '0;
         queued_ff     <= '0;
      end else if (req_fire) begin
         run_valid_ff  <= run_valid_in;
         run_task_ff   <= run_task_in;
         slice_left_ff <= slice_left_in;
         tick_ff       <= tick_in;
         term_ff       <= term_in;
         queued_ff     <= queued_in;
      end
   end

   // Response register: load on a request transfer, drop on a response transfer
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff    <= status_in;
         rsp_run_valid_ff <= run_valid_in;
         rsp_run_task_ff  <= run_valid_in ? run_task_in : '0;
         rsp_switched_ff  <= switched_in;
         rsp_prior_ff     <= prior_in;
         rsp_level_ff     <= level_next;
         rsp_tick_ff      <= tick_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_run_valid     = rsp_run_valid_ff;
   assign rsp_run_task      = rsp_run_task_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_prior_task    = rsp_prior_ff;
   assign rsp_waiting_count = rsp_level_ff;
   assign rsp_tick_total    = rsp_tick_ff;

endmodule
